// ===== src/lsh_pkg.sv =====
// Shared types, register map and the sharpening arithmetic for the 3x3 sharpener.
// No dependencies; imported by every module of the block.
package lsh_pkg;

    localparam int PIX_W  = 8;
    localparam int ROW_W  = 12;
    localparam int OCOL_W = 10;
    localparam int IMGW_W = 11;
    localparam int WGT_W  = 4;
    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    // register indexes (paddr[3:2])
    localparam logic [1:0] REG_IMG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_IMG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_WEIGHT     = 2'd2;

    localparam logic [IMGW_W-1:0] IMG_WIDTH_RST  = 11'd640;
    localparam logic [ROW_W-1:0]  IMG_HEIGHT_RST = 12'd480;
    localparam logic [WGT_W-1:0]  WEIGHT_RST     = 4'd5;

    typedef logic [PIX_W-1:0] t_pix;

    // (4+w)*c - u - d - l - r, clamped to 0..255
    function automatic t_pix lsh_sharpen(input logic [WGT_W-1:0] w, input t_pix c,
                                         input t_pix u, input t_pix d,
                                         input t_pix l, input t_pix r);
        logic [12:0] k;
        logic [12:0] prod;
        logic [12:0] neg;
        logic [12:0] diff;
        t_pix        res;
        k    = 13'(w) + 13'd4;
        prod = k * 13'(c);
        neg  = 13'(u) + 13'(d) + 13'(l) + 13'(r);
        diff = prod - neg;
        if (prod < neg) begin
            res = '0;
        end else if (diff > 13'd255) begin
            res = 8'd255;
        end else begin
            res = diff[7:0];
        end
        return res;
    endfunction

endpackage

// ===== src/laplacian_sharpen_3x3.sv =====
// Top level of the 3x3 sharpening filter: APB registers, position counters,
// pipeline control and output register. Uses lsh_pkg, lsh_line_store, lsh_calc.
//
// Usage:
//  - Slave stream: one 8-bit pixel per item in raster order; s_tuser marks
//    the first pixel of a frame and clears row and column.
//  - Master stream: one item per interior pixel (neither first/last row nor
//    first/last column): value, column and row of the pixel one row up and
//    one column left of the pixel just taken. m_tlast flags the last interior
//    pixel of the frame. Border positions produce no item.
//  - APB: image_width at 0x0, image_height at 0x4, center_weight at 0x8.
//    Write only while the stream is idle.
//  - Throughput: one pixel per cycle while s_tready is high. Pipeline: two
//    register stages; an accepted pixel is registered in stage two, then in
//    the output register, which drives m_tvalid and m_tdata.
//  - The line store is one read port and one write port; a pixel reads its
//    column in the accept cycle and writes it back when it leaves stage two.
//  - Stall: when m_tready is low the output register holds; stage two keeps
//    its pixel only if it would produce an item, and s_tready drops once
//    stage two is occupied and blocked. Border pixels never stall.
//  - Reset: counters at row 0 column 0, registers at 640x480 weight 5, no
//    items in flight. The line store is not cleared: the first rows of a
//    frame write every entry before its data reaches an emitted item.
module laplacian_sharpen_3x3 import lsh_pkg::*; #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // APB configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    // pixel input
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,   // [7:0] pixel_in
    input  logic              s_tuser,   // frame_start
    // result output
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [31:0]       m_tdata,   // [7:0] out_pixel, [17:8] out_col, [29:18] out_row
    output logic              m_tlast    // last_of_frame
);

    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

    // ---------------- configuration registers ----------------
    logic [IMGW_W-1:0] r_img_w;
    logic [ROW_W-1:0]  r_img_h;
    logic [WGT_W-1:0]  r_weight;
    logic              cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_w  <= IMG_WIDTH_RST;
            r_img_h  <= IMG_HEIGHT_RST;
            r_weight <= WEIGHT_RST;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_IMG_WIDTH:  r_img_w  <= pwdata[IMGW_W-1:0];
                REG_IMG_HEIGHT: r_img_h  <= pwdata[ROW_W-1:0];
                REG_WEIGHT:     r_weight <= pwdata[WGT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_IMG_WIDTH:  prdata = APB_DW'(r_img_w);
            REG_IMG_HEIGHT: prdata = APB_DW'(r_img_h);
            REG_WEIGHT:     prdata = APB_DW'(r_weight);
            default:        prdata = '0;
        endcase
    end

    // effective last column / row (width 3..MAX_WIDTH, height >= 3)
    logic [12:0]      w_eff;
    logic [CW-1:0]    col_last;
    logic [ROW_W-1:0] row_last;

    always_comb begin
        if ({2'b00, r_img_w} < 13'd3) begin
            w_eff = 13'd3;
        end else if ({2'b00, r_img_w} > 13'(MAX_WIDTH)) begin
            w_eff = 13'(MAX_WIDTH);
        end else begin
            w_eff = {2'b00, r_img_w};
        end
        col_last = CW'(w_eff - 13'd1);
        row_last = (r_img_h < 12'd3) ? 12'd2 : r_img_h - 12'd1;
    end

    // ---------------- stage A: accept, position ----------------
    logic [CW-1:0]     r_col;
    logic [ROW_W-1:0]  r_row;
    logic [CW-1:0]     a_col;
    logic [ROW_W-1:0]  a_row;
    logic [OCOL_W-1:0] a_col_m1;
    logic              a_acc;

    assign a_acc    = s_tvalid && s_tready;
    assign a_col    = s_tuser ? '0 : r_col;
    assign a_row    = s_tuser ? '0 : r_row;
    assign a_col_m1 = OCOL_W'(a_col - CW'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (a_acc) begin
            if (a_col >= col_last) begin
                r_col <= '0;
                r_row <= (a_row >= row_last) ? '0 : a_row + 12'd1;
            end else begin
                r_col <= a_col + CW'(1);
                r_row <= a_row;
            end
        end
    end

    // ---------------- stage B: line-store data, window, arithmetic ----------------
    logic              r_b_valid;
    logic              r_b_emit;
    logic              r_b_last;
    t_pix              r_b_pix;
    logic [CW-1:0]     r_b_col;
    logic [OCOL_W-1:0] r_b_ocol;
    logic [ROW_W-1:0]  r_b_orow;
    logic              b_fire;
    logic              out_free;
    t_pix              row1, row2, value;

    assign out_free = !m_tvalid || m_tready;
    assign b_fire   = r_b_valid && (!r_b_emit || out_free);
    assign s_tready = !r_b_valid || b_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (s_tready) begin
            r_b_valid <= s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_acc) begin
            r_b_emit <= (a_col >= CW'(2)) && (a_row >= 12'd2);
            r_b_last <= (a_col == col_last) && (a_row == row_last);
            r_b_pix  <= s_tdata;
            r_b_col  <= a_col;
            r_b_ocol <= a_col_m1;
            r_b_orow <= a_row - 12'd1;
        end
    end

    lsh_line_store #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (a_acc),
        .i_rd_addr (a_col),
        .i_wr_en   (b_fire),
        .i_wr_addr (r_b_col),
        .i_wr_row1 (r_b_pix),
        .i_wr_row2 (row1),
        .o_row1    (row1),
        .o_row2    (row2)
    );

    lsh_calc u_calc (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_shift  (b_fire),
        .i_pixel  (r_b_pix),
        .i_row1   (row1),
        .i_row2   (row2),
        .i_weight (r_weight),
        .o_value  (value)
    );

    // ---------------- output register ----------------
    logic              r_m_valid;
    logic              r_m_last;
    t_pix              r_m_pix;
    logic [OCOL_W-1:0] r_m_col;
    logic [ROW_W-1:0]  r_m_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (b_fire && r_b_emit) begin
            r_m_valid <= 1'b1;
        end else if (m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_fire && r_b_emit) begin
            r_m_pix  <= value;
            r_m_col  <= r_b_ocol;
            r_m_row  <= r_b_orow;
            r_m_last <= r_b_last;
        end
    end

    assign m_tvalid = r_m_valid;
    assign m_tlast  = r_m_last;
    assign m_tdata  = {2'b00, r_m_row, r_m_col, r_m_pix};

endmodule

// ===== src/lsh_line_store.sv =====
// Two-bank line store (row-1 and row-2) with registered read.
// Forwards a same-cycle write to the read port. Uses lsh_pkg.
module lsh_line_store import lsh_pkg::*; #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  t_pix          i_wr_row1,
    input  t_pix          i_wr_row2,
    output t_pix          o_row1,
    output t_pix          o_row2
);

    t_pix bank1 [DEPTH];
    t_pix bank2 [DEPTH];

    t_pix r_q1, r_q2;
    logic r_fwd;
    t_pix r_fwd1, r_fwd2;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            bank1[i_wr_addr] <= i_wr_row1;
            bank2[i_wr_addr] <= i_wr_row2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_q1 <= bank1[i_rd_addr];
            r_q2 <= bank2[i_rd_addr];
        end
    end

    // read and write of the same entry in one cycle: take the new data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd <= 1'b0;
        end else if (i_rd_en) begin
            r_fwd <= i_wr_en && (i_wr_addr == i_rd_addr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_fwd1 <= i_wr_row1;
            r_fwd2 <= i_wr_row2;
        end
    end

    assign o_row1 = r_fwd ? r_fwd1 : r_q1;
    assign o_row2 = r_fwd ? r_fwd2 : r_q2;

endmodule

// ===== src/lsh_calc.sv =====
// 3x3 window registers (two previous columns) and the sharpening datapath.
// Uses lsh_pkg for lsh_sharpen.
module lsh_calc import lsh_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_shift,
    input  t_pix             i_pixel,
    input  t_pix             i_row1,
    input  t_pix             i_row2,
    input  logic [WGT_W-1:0] i_weight,
    output t_pix             o_value
);

    // [0..2] older column top/mid/bot, [3..5] newer column
    t_pix r_win [6];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 6; i++) begin
                r_win[i] <= '0;
            end
        end else if (i_shift) begin
            r_win[0] <= r_win[3];
            r_win[1] <= r_win[4];
            r_win[2] <= r_win[5];
            r_win[3] <= i_row2;
            r_win[4] <= i_row1;
            r_win[5] <= i_pixel;
        end
    end

    // center r_win[4]; up r_win[3], down r_win[5], left r_win[1], right = row-1 now
    assign o_value = lsh_sharpen(i_weight, r_win[4], r_win[3], r_win[5], r_win[1], i_row1);

endmodule

// ===== src/lsh_checker.sv =====
// Port-level checks for laplacian_sharpen_3x3, attached by bind.
// Depends on lsh_pkg and the top level's port list.
module lsh_checker import lsh_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              psel,
    input logic              penable,
    input logic              pwrite,
    input logic [APB_AW-1:0] paddr,
    input logic [APB_DW-1:0] pwdata,
    input logic [APB_DW-1:0] prdata,
    input logic              pready,
    input logic              m_tvalid,
    input logic              m_tready,
    input logic [31:0]       m_tdata,
    input logic              m_tlast
);

    // reset empties the output register
    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> !m_tvalid)
        else $error("m_tvalid high after reset");

    // a stalled item holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output item changed while stalled");

    // emitted items never carry row 0 (the first border row)
    a_interior: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> m_tdata[29:18] != 12'd0)
        else $error("border row emitted");

    // weight register reads back what was written
    a_weight_rb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (psel && penable && pwrite && pready && paddr[3:2] == REG_WEIGHT) ##1
        (paddr[3:2] == REG_WEIGHT) |-> prdata[3:0] == $past(pwdata[3:0]))
        else $error("center_weight readback mismatch");

endmodule

bind laplacian_sharpen_3x3 lsh_checker u_lsh_checker (.*);
